### design/fpe_pkg.sv
// ----------------------------------------------------------------------------
// fpe_pkg - shared types and constants of the Fourier position encoder
// Beat structs for the command and result channels, the CORDIC tag that
// travels down the pipeline, and the fixed-point constants of the encoder.
// ----------------------------------------------------------------------------
package fpe_pkg;

	// Command codes
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_ENCODE = 1'b1;

	// Field widths fixed by the beat format
	localparam int IDX_W   = 7;
	localparam int COORD_W = 17;
	localparam int COEF_W  = 16;
	localparam int OUT_W   = 16;

	// Internal datapath widths
	localparam int CXY_W  = 18;                // 2c-1 in Q1.16, signed
	localparam int PROD_W = CXY_W + COEF_W;    // one product, signed
	localparam int DOT_W  = 28;                // fraction bits of a turn kept
	localparam int PH_W   = 32;                // phase in 2^-32 turns
	localparam int ZW     = 34;                // residual angle, signed
	localparam int CW     = 33;                // CORDIC vector, Q30 signed

	// Fixed-point constants
	localparam logic [COORD_W-1:0] ONE_Q16      = 17'd65536;
	localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [ZW-1:0] HALF_TURN    = 34'sd2147483648;
	localparam logic signed [CW-1:0] CORDIC_GAIN  = 33'sd652032874;
	localparam logic signed [CW+1:0] ROUND_HALF   = 35'sd32768;
	localparam logic signed [18:0]   Q14_MAX      = 19'sd16384;
	localparam logic signed [18:0]   Q14_MIN      = -19'sd16384;

	// Arctangent of 2^-i in 2^-32 turns
	localparam int ATAN_COUNT = 24;
	localparam logic [31:0] ATAN_TURNS [ATAN_COUNT] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41721,     32'd20860,
		32'd10430,     32'd5215,      32'd2607,      32'd1303,
		32'd651,       32'd325,       32'd162,       32'd81
	};

	// Command beat
	typedef struct packed {
		logic                       mode;
		logic [IDX_W-1:0]           feat_index;
		logic [COORD_W-1:0]         x_coord;
		logic [COORD_W-1:0]         y_coord;
		logic signed [COEF_W-1:0]   coef_x;
		logic signed [COEF_W-1:0]   coef_y;
	} cmd_t;

	// Result beat
	typedef struct packed {
		logic [IDX_W-1:0]           out_index;
		logic signed [OUT_W-1:0]    sin_value;
		logic signed [OUT_W-1:0]    cos_value;
	} rsp_t;

	// Control that travels with each item through the rotator
	typedef struct packed {
		logic                       valid;
		logic                       flip;
		logic [IDX_W-1:0]           idx;
	} tag_t;

endpackage

### design/fpe_cordic.sv
// ----------------------------------------------------------------------------
// fpe_cordic - pipelined rotation-mode CORDIC for sine and cosine
// One register stage per micro-rotation, then a rounding stage that undoes
// the half-turn fold and rounds Q30 results to saturated Q1.14.
// ----------------------------------------------------------------------------
module fpe_cordic #(
	parameter int STAGES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [fpe_pkg::ZW-1:0]     z_in,
	input  fpe_pkg::tag_t                     tag_in,
	output fpe_pkg::tag_t                     tag_out,
	output logic signed [fpe_pkg::OUT_W-1:0]  sin_out,
	output logic signed [fpe_pkg::OUT_W-1:0]  cos_out
);
	import fpe_pkg::*;

	// Entry 0 is the start vector, entry i+1 the output of micro-rotation i
	logic signed [CW-1:0] cv_sn  [STAGES+1];
	logic signed [CW-1:0] sv_sn  [STAGES+1];
	logic signed [ZW-1:0] z_sn   [STAGES+1];
	tag_t                 tag_sn [STAGES+1];

	assign cv_sn[0]  = CORDIC_GAIN;
	assign sv_sn[0]  = '0;
	assign z_sn[0]   = z_in;
	assign tag_sn[0] = tag_in;

	// Micro-rotation chain
	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		localparam logic signed [ZW-1:0] ATAN_I = ZW'(ATAN_TURNS[i]);
		logic signed [CW-1:0] dc;
		logic signed [CW-1:0] ds;

		assign dc = sv_sn[i] >>> i;
		assign ds = cv_sn[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_sn[i+1] <= '0;
			end else begin
				tag_sn[i+1] <= tag_sn[i];
			end
		end

		always_ff @(posedge clk) begin
			if (!z_sn[i][ZW-1]) begin
				cv_sn[i+1] <= cv_sn[i] - dc;
				sv_sn[i+1] <= sv_sn[i] + ds;
				z_sn[i+1]  <= z_sn[i] - ATAN_I;
			end else begin
				cv_sn[i+1] <= cv_sn[i] + dc;
				sv_sn[i+1] <= sv_sn[i] - ds;
				z_sn[i+1]  <= z_sn[i] + ATAN_I;
			end
		end
	end

	// Round half up to Q1.14, negating when the phase was folded
	logic signed [CW+1:0] sin_sum;
	logic signed [CW+1:0] cos_sum;
	logic signed [18:0]   sin_q;
	logic signed [18:0]   cos_q;
	logic signed [OUT_W-1:0] sin_sat;
	logic signed [OUT_W-1:0] cos_sat;

	always_comb begin
		if (tag_sn[STAGES].flip) begin
			sin_sum = ROUND_HALF - (CW+2)'(sv_sn[STAGES]);
			cos_sum = ROUND_HALF - (CW+2)'(cv_sn[STAGES]);
		end else begin
			sin_sum = ROUND_HALF + (CW+2)'(sv_sn[STAGES]);
			cos_sum = ROUND_HALF + (CW+2)'(cv_sn[STAGES]);
		end
		sin_q = sin_sum[CW+1:16];
		cos_q = cos_sum[CW+1:16];

		if (sin_q > Q14_MAX)       sin_sat = OUT_W'(Q14_MAX);
		else if (sin_q < Q14_MIN)  sin_sat = OUT_W'(Q14_MIN);
		else                       sin_sat = OUT_W'(sin_q);

		if (cos_q > Q14_MAX)       cos_sat = OUT_W'(Q14_MAX);
		else if (cos_q < Q14_MIN)  cos_sat = OUT_W'(Q14_MIN);
		else                       cos_sat = OUT_W'(cos_q);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else begin
			tag_out <= tag_sn[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		sin_out <= sin_sat;
		cos_out <= cos_sat;
	end

endmodule

### design/fourier_position_encoder_unit.sv
// ----------------------------------------------------------------------------
// fourier_position_encoder_unit - random Fourier positional encoding
// Loads Gaussian coefficient pairs into a table and, per encode beat, returns
// sine and cosine of 2*pi times the dot product of (2x-1, 2y-1) with a pair.
//
//   channel | signals                 | direction | flow control
//   --------+-------------------------+-----------+-----------------------------
//   command | start, busy, cmd        | in        | taken when start && !busy
//   result  | rsp_strobe, rsp         | out       | one cycle per beat, no hold
//
// Encode beats pass the three front stages, the rotator and the output
// register; loads give no result. One beat of either kind is taken every
// cycle; busy stays low since the pipeline never stalls. The coefficient
// table is a RAM with a registered read: a load is visible to an encode in
// the very next cycle. Reset clears only the tag registers of the pipeline;
// the table holds garbage until written.
// ----------------------------------------------------------------------------
module fourier_position_encoder_unit #(
	parameter int NUM_FEATS    = 128,
	parameter int ANGLE_STAGES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  fpe_pkg::cmd_t cmd,
	output logic          rsp_strobe,
	output fpe_pkg::rsp_t rsp
);
	import fpe_pkg::*;

	localparam int ADDR_W  = (NUM_FEATS > 1) ? $clog2(NUM_FEATS) : 1;
	localparam int LATENCY = ANGLE_STAGES + 4;

	assign busy = 1'b0;

	// Command decode
	logic             take;
	logic             in_range;
	logic [ADDR_W-1:0] addr;

	assign take     = start && !busy;
	assign in_range = 32'(cmd.feat_index) < NUM_FEATS;
	assign addr     = ADDR_W'(cmd.feat_index);

	// Coefficient table: coef_x in the upper half, coef_y in the lower
	logic [2*COEF_W-1:0] coef_mem [NUM_FEATS];
	logic [2*COEF_W-1:0] coef_s1;

	always_ff @(posedge clk) begin
		if (take && cmd.mode == MODE_LOAD && in_range) begin
			coef_mem[addr] <= {cmd.coef_x, cmd.coef_y};
		end
		coef_s1 <= coef_mem[addr];
	end

	// Stage 1: clamp coordinates and map to 2c-1
	logic [COORD_W-1:0]     x_cl;
	logic [COORD_W-1:0]     y_cl;
	logic signed [18:0]     cx_w;
	logic signed [18:0]     cy_w;
	logic signed [CXY_W-1:0] cx_s1;
	logic signed [CXY_W-1:0] cy_s1;
	tag_t                   tag_s1;

	always_comb begin
		x_cl = (cmd.x_coord > ONE_Q16) ? ONE_Q16 : cmd.x_coord;
		y_cl = (cmd.y_coord > ONE_Q16) ? ONE_Q16 : cmd.y_coord;
		cx_w = $signed({1'b0, x_cl, 1'b0}) - $signed({2'b00, ONE_Q16});
		cy_w = $signed({1'b0, y_cl, 1'b0}) - $signed({2'b00, ONE_Q16});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.valid <= take && cmd.mode == MODE_ENCODE && in_range;
			tag_s1.flip  <= 1'b0;
			tag_s1.idx   <= cmd.feat_index;
		end
	end

	always_ff @(posedge clk) begin
		cx_s1 <= CXY_W'(cx_w);
		cy_s1 <= CXY_W'(cy_w);
	end

	// Stage 2: the two products
	logic signed [COEF_W-1:0] kx;
	logic signed [COEF_W-1:0] ky;
	logic signed [PROD_W-1:0] px_s2;
	logic signed [PROD_W-1:0] py_s2;
	tag_t                     tag_s2;

	assign kx = $signed(coef_s1[2*COEF_W-1:COEF_W]);
	assign ky = $signed(coef_s1[COEF_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		px_s2 <= cx_s1 * kx;
		py_s2 <= cy_s1 * ky;
	end

	// Stage 3: sum, keep the fraction of a turn, fold into a quarter turn
	logic [DOT_W-1:0]       dot_lo;
	logic signed [PH_W-1:0] phase;
	logic signed [ZW-1:0]   z_raw;
	logic signed [ZW-1:0]   z_fold;
	logic                   flip;
	logic signed [ZW-1:0]   z_s3;
	tag_t                   tag_s3;

	always_comb begin
		dot_lo = DOT_W'(px_s2 + py_s2);
		phase  = $signed({dot_lo, 4'b0000});
		z_raw  = ZW'(phase);
		if (z_raw > QUARTER_TURN) begin
			z_fold = z_raw - HALF_TURN;
			flip   = 1'b1;
		end else if (z_raw < -QUARTER_TURN) begin
			z_fold = z_raw + HALF_TURN;
			flip   = 1'b1;
		end else begin
			z_fold = z_raw;
			flip   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else begin
			tag_s3.valid <= tag_s2.valid;
			tag_s3.flip  <= flip;
			tag_s3.idx   <= tag_s2.idx;
		end
	end

	always_ff @(posedge clk) begin
		z_s3 <= z_fold;
	end

	// Rotator and output rounding
	tag_t                    tag_out;
	logic signed [OUT_W-1:0] sin_out;
	logic signed [OUT_W-1:0] cos_out;

	fpe_cordic #(
		.STAGES (ANGLE_STAGES)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.z_in    (z_s3),
		.tag_in  (tag_s3),
		.tag_out (tag_out),
		.sin_out (sin_out),
		.cos_out (cos_out)
	);

	assign rsp_strobe    = tag_out.valid;
	assign rsp.out_index = tag_out.idx;
	assign rsp.sin_value = sin_out;
	assign rsp.cos_value = cos_out;

`ifndef SYNTHESIS
	// An encode beat comes out at the end of the pipeline, same index
	a_encode_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.mode == MODE_ENCODE && 32'(cmd.feat_index) < NUM_FEATS)
		|-> ##LATENCY (rsp_strobe && rsp.out_index == $past(cmd.feat_index, LATENCY)))
		else $error("encode beat lost or index mismatch");

	// Loads and out-of-range encodes produce nothing
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.mode == MODE_LOAD || 32'(cmd.feat_index) >= NUM_FEATS))
		|-> ##LATENCY !rsp_strobe)
		else $error("result beat without an encode command");

	// Saturation keeps both outputs within plus or minus one
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_strobe |-> (rsp.sin_value >= -16'sd16384 && rsp.sin_value <= 16'sd16384
			&& rsp.cos_value >= -16'sd16384 && rsp.cos_value <= 16'sd16384))
		else $error("result outside Q1.14 range");
`endif

endmodule
